// ===== src/hgsd_pkg.sv =====
// Shared types, widths and codes for the heat grid stencil derivative block.
// Used by the controller, the datapath and the top level. No dependencies.
package hgsd_pkg;

    localparam int DEF_MAX_COLUMNS = 64;
    localparam int DEF_MAX_ROWS    = 64;

    localparam int RC_W       = 6;
    localparam int TEMP_W     = 24;
    localparam int OUT_W      = 48;
    localparam int GRID_W     = 7;
    localparam int COEF_W     = 16;
    localparam int SRC_W      = 12;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam int DIFF_W = TEMP_W + 2;
    localparam int MUL_AW = DIFF_W + 1;
    localparam int MUL_BW = COEF_W + 1;
    localparam int ACC_W  = MUL_AW + MUL_BW;
    localparam int LO_W   = 22;
    localparam int FULL_W = 62;

    localparam int RESET_TEMP = 5120;

    localparam logic CMD_WRITE   = 1'b0;
    localparam logic CMD_COMPUTE = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_GRID_COLUMNS  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CONDUCTANCE_X = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CONDUCTANCE_Y = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HEAT_GAIN     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_CELL   = 3'd5;

    localparam logic [GRID_W-1:0] RST_GRID_COLUMNS = 7'd16;
    localparam logic [GRID_W-1:0] RST_GRID_ROWS    = 7'd16;
    localparam logic [COEF_W-1:0] RST_COEF         = 16'd256;
    localparam logic [SRC_W-1:0]  RST_SOURCE_CELL  = 12'd136;

    localparam logic [2:0] RD_C = 3'd0;
    localparam logic [2:0] RD_N = 3'd1;
    localparam logic [2:0] RD_S = 3'd2;
    localparam logic [2:0] RD_W = 3'd3;
    localparam logic [2:0] RD_E = 3'd4;

    localparam logic [1:0] MUL_Y  = 2'd0;
    localparam logic [1:0] MUL_X  = 2'd1;
    localparam logic [1:0] MUL_LO = 2'd2;
    localparam logic [1:0] MUL_HI = 2'd3;

    typedef struct packed {
        logic       clr_we;
        logic       in_write;
        logic       in_load;
        logic [2:0] rd_sel;
        logic       cap_c;
        logic       cap_n;
        logic       cap_s;
        logic       cap_w;
        logic [1:0] mul_op;
        logic       acc_init;
        logic       acc_add;
        logic       pl_load;
        logic       ph_load;
        logic       out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic clr_last;
        logic out_free;
    } t_dp_status;

endpackage

// ===== src/hgsd_ctrl.sv =====
// Controller state machine: clearing pass, input handshake and the read and
// multiply sequence of a compute transaction. Depends on hgsd_pkg.
module hgsd_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_command,
    input  hgsd_pkg::t_dp_status i_status,
    output logic                o_in_ready,
    output hgsd_pkg::t_dp_cmd   o_cmd
);
    import hgsd_pkg::*;

    localparam logic [3:0] S_CLR  = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_RC   = 4'd2;
    localparam logic [3:0] S_RN   = 4'd3;
    localparam logic [3:0] S_RS   = 4'd4;
    localparam logic [3:0] S_RW   = 4'd5;
    localparam logic [3:0] S_RE   = 4'd6;
    localparam logic [3:0] S_MX   = 4'd7;
    localparam logic [3:0] S_ML   = 4'd8;
    localparam logic [3:0] S_MH   = 4'd9;
    localparam logic [3:0] S_SUM  = 4'd10;

    logic [3:0] r_state;
    logic [3:0] n_state;
    logic       in_fire;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_fire    = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.rd_sel = RD_C;
        o_cmd.mul_op = MUL_Y;
        case (r_state)
            S_CLR: begin
                o_cmd.clr_we = 1'b1;
                if (i_status.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_cmd.in_write = in_fire && (i_command == CMD_WRITE);
                o_cmd.in_load  = in_fire && (i_command == CMD_COMPUTE);
                if (in_fire && (i_command == CMD_COMPUTE)) begin
                    n_state = S_RC;
                end
            end
            S_RC: begin
                n_state = S_RN;
            end
            S_RN: begin
                o_cmd.rd_sel = RD_N;
                o_cmd.cap_c  = 1'b1;
                n_state      = S_RS;
            end
            S_RS: begin
                o_cmd.rd_sel = RD_S;
                o_cmd.cap_n  = 1'b1;
                n_state      = S_RW;
            end
            S_RW: begin
                o_cmd.rd_sel = RD_W;
                o_cmd.cap_s  = 1'b1;
                n_state      = S_RE;
            end
            S_RE: begin
                o_cmd.rd_sel   = RD_E;
                o_cmd.cap_w    = 1'b1;
                o_cmd.mul_op   = MUL_Y;
                o_cmd.acc_init = 1'b1;
                n_state        = S_MX;
            end
            S_MX: begin
                o_cmd.mul_op  = MUL_X;
                o_cmd.acc_add = 1'b1;
                n_state       = S_ML;
            end
            S_ML: begin
                o_cmd.mul_op  = MUL_LO;
                o_cmd.pl_load = 1'b1;
                n_state       = S_MH;
            end
            S_MH: begin
                o_cmd.mul_op  = MUL_HI;
                o_cmd.ph_load = 1'b1;
                n_state       = S_SUM;
            end
            S_SUM: begin
                o_cmd.out_load = i_status.out_free;
                if (i_status.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
        end else begin
            r_state <= n_state;
        end
    end

    a_compute_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && (i_command == CMD_COMPUTE)) |=> (r_state == S_RC))
        else $error("compute transaction did not start the read sequence");

    a_write_stays_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && (i_command == CMD_WRITE)) |=> (r_state == S_IDLE))
        else $error("write transaction left idle");

    a_sum_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_SUM) && !i_status.out_free) |=> (r_state == S_SUM))
        else $error("result dropped while output busy");

    a_clear_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_CLR) && !i_status.clr_last) |=> (r_state == S_CLR))
        else $error("clearing pass ended early");

endmodule

// ===== src/hgsd_datapath.sv =====
// Datapath: config registers, grid memory with clear counter, neighbor
// registers, shared multiplier, accumulator and output register. Uses hgsd_pkg.
module hgsd_datapath #(
    parameter int MAX_COLUMNS = hgsd_pkg::DEF_MAX_COLUMNS,
    parameter int MAX_ROWS    = hgsd_pkg::DEF_MAX_ROWS
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  hgsd_pkg::t_dp_cmd                      i_cmd,
    output hgsd_pkg::t_dp_status                   o_status,
    input  logic                                   i_cfg_we,
    input  logic [hgsd_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [hgsd_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    input  logic [hgsd_pkg::RC_W-1:0]              i_cell_row,
    input  logic [hgsd_pkg::RC_W-1:0]              i_cell_column,
    input  logic signed [hgsd_pkg::TEMP_W-1:0]     i_temperature,
    input  logic signed [hgsd_pkg::TEMP_W-1:0]     i_heat_power,
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output logic signed [hgsd_pkg::OUT_W-1:0]      o_derivative
);
    import hgsd_pkg::*;

    localparam int DEPTH = MAX_ROWS * MAX_COLUMNS;
    localparam int AW    = $clog2(DEPTH);
    localparam int CDW   = $clog2(MAX_COLUMNS + 1);
    localparam int RDW   = $clog2(MAX_ROWS + 1);
    localparam logic signed [FULL_W-1:0] ROUND_BIAS = FULL_W'(128);
    localparam logic signed [OUT_W-1:0]  OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic signed [OUT_W-1:0]  OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

    function automatic logic [AW-1:0] cell_addr(input int row, input int col);
        return AW'(row * MAX_COLUMNS + col);
    endfunction

    logic [GRID_W-1:0] r_grid_columns;
    logic [GRID_W-1:0] r_grid_rows;
    logic [COEF_W-1:0] r_cond_x;
    logic [COEF_W-1:0] r_cond_y;
    logic [COEF_W-1:0] r_gain;
    logic [SRC_W-1:0]  r_source_cell;

    logic signed [TEMP_W-1:0] mem [DEPTH];
    logic signed [TEMP_W-1:0] r_rd;
    logic [AW-1:0]            r_clr_addr;

    logic [RC_W-1:0]          r_row;
    logic [RC_W-1:0]          r_col;
    logic signed [TEMP_W-1:0] r_power;
    logic signed [TEMP_W-1:0] r_c;
    logic signed [TEMP_W-1:0] r_n;
    logic signed [TEMP_W-1:0] r_s;
    logic signed [TEMP_W-1:0] r_w;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [ACC_W-1:0]  r_pl;
    logic signed [ACC_W-1:0]  r_ph;
    logic                     r_out_valid;
    logic signed [OUT_W-1:0]  r_out_data;

    logic [CDW-1:0] cols;
    logic [RDW-1:0] rows;
    logic           in_grid;
    logic           inner;
    logic           is_src;
    logic           in_storage;
    logic [AW-1:0]  rd_addr;
    logic [AW-1:0]  mem_addr;
    logic           mem_we;
    logic signed [TEMP_W-1:0] mem_wdata;

    logic signed [TEMP_W-1:0] n_eff;
    logic signed [TEMP_W-1:0] s_eff;
    logic signed [TEMP_W-1:0] e_eff;
    logic signed [DIFF_W-1:0] dy;
    logic signed [DIFF_W-1:0] dx;
    logic signed [MUL_AW-1:0] mul_a;
    logic signed [MUL_BW-1:0] mul_b;
    logic signed [ACC_W-1:0]  mul_p;
    logic signed [ACC_W-1:0]  src_term;
    logic signed [FULL_W-1:0] full;
    logic signed [FULL_W-1:0] shv;
    logic signed [OUT_W-1:0]  sat;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_columns <= RST_GRID_COLUMNS;
            r_grid_rows    <= RST_GRID_ROWS;
            r_cond_x       <= RST_COEF;
            r_cond_y       <= RST_COEF;
            r_gain         <= RST_COEF;
            r_source_cell  <= RST_SOURCE_CELL;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_GRID_COLUMNS:  r_grid_columns <= i_cfg_data[GRID_W-1:0];
                REG_GRID_ROWS:     r_grid_rows    <= i_cfg_data[GRID_W-1:0];
                REG_CONDUCTANCE_X: r_cond_x       <= i_cfg_data[COEF_W-1:0];
                REG_CONDUCTANCE_Y: r_cond_y       <= i_cfg_data[COEF_W-1:0];
                REG_HEAT_GAIN:     r_gain         <= i_cfg_data[COEF_W-1:0];
                REG_SOURCE_CELL:   r_source_cell  <= i_cfg_data[SRC_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // grid geometry of the latched cell
    always_comb begin
        if (int'(r_grid_columns) < 3) begin
            cols = CDW'(3);
        end else if (int'(r_grid_columns) > MAX_COLUMNS) begin
            cols = CDW'(MAX_COLUMNS);
        end else begin
            cols = CDW'(r_grid_columns);
        end
        if (int'(r_grid_rows) < 3) begin
            rows = RDW'(3);
        end else if (int'(r_grid_rows) > MAX_ROWS) begin
            rows = RDW'(MAX_ROWS);
        end else begin
            rows = RDW'(r_grid_rows);
        end
    end

    assign in_grid = (int'(r_row) < int'(rows)) && (int'(r_col) < int'(cols));
    assign inner   = (r_row != '0) && (int'(r_row) + 2 <= int'(rows)) &&
                     (r_col != '0) && (int'(r_col) + 2 <= int'(cols));
    assign is_src  = (int'(r_row) * int'(cols) + int'(r_col)) == int'(r_source_cell);
    assign in_storage = (int'(i_cell_row) < MAX_ROWS) && (int'(i_cell_column) < MAX_COLUMNS);

    always_comb begin
        rd_addr = cell_addr(int'(r_row), int'(r_col));
        if (inner) begin
            case (i_cmd.rd_sel)
                RD_N:    rd_addr = cell_addr(int'(r_row) - 1, int'(r_col));
                RD_S:    rd_addr = cell_addr(int'(r_row) + 1, int'(r_col));
                RD_W:    rd_addr = cell_addr(int'(r_row), int'(r_col) - 1);
                RD_E:    rd_addr = cell_addr(int'(r_row), int'(r_col) + 1);
                default: rd_addr = cell_addr(int'(r_row), int'(r_col));
            endcase
        end
    end

    always_comb begin
        if (i_cmd.clr_we) begin
            mem_addr  = r_clr_addr;
            mem_wdata = TEMP_W'(RESET_TEMP);
            mem_we    = 1'b1;
        end else if (i_cmd.in_write) begin
            mem_addr  = cell_addr(int'(i_cell_row), int'(i_cell_column));
            mem_wdata = i_temperature;
            mem_we    = in_storage;
        end else begin
            mem_addr  = rd_addr;
            mem_wdata = i_temperature;
            mem_we    = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_addr] <= mem_wdata;
        end
        r_rd <= mem[mem_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clr_we) begin
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    assign o_status.clr_last = (r_clr_addr == AW'(DEPTH - 1));
    assign o_status.out_free = !r_out_valid || i_out_ready;

    // stencil terms; the center stands in for neighbors on the grid edge
    assign n_eff = (r_row == RC_W'(1)) ? r_c : r_n;
    assign s_eff = (int'(r_row) + 2 == int'(rows)) ? r_c : r_s;
    assign e_eff = (int'(r_col) + 2 == int'(cols)) ? r_c : r_rd;
    assign dy = DIFF_W'(n_eff) + DIFF_W'(s_eff) - (DIFF_W'(r_c) <<< 1);
    assign dx = DIFF_W'((r_col == RC_W'(1)) ? r_c : r_w) + DIFF_W'(e_eff)
              - (DIFF_W'(r_c) <<< 1);

    always_comb begin
        case (i_cmd.mul_op)
            MUL_Y: begin
                mul_a = inner ? MUL_AW'(dy) : '0;
                mul_b = $signed({1'b0, r_cond_y});
            end
            MUL_X: begin
                mul_a = inner ? MUL_AW'(dx) : '0;
                mul_b = $signed({1'b0, r_cond_x});
            end
            MUL_LO: begin
                mul_a = $signed({{(MUL_AW-LO_W){1'b0}}, r_acc[LO_W-1:0]});
                mul_b = $signed({1'b0, r_gain});
            end
            MUL_HI: begin
                mul_a = MUL_AW'($signed(r_acc[ACC_W-1:LO_W]));
                mul_b = $signed({1'b0, r_gain});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p    = mul_a * mul_b;
    assign src_term = (in_grid && is_src) ? (ACC_W'(r_power) <<< 8) : '0;

    // round to Q.16, floor, saturate
    assign full = (FULL_W'(r_ph) <<< LO_W) + FULL_W'(r_pl) + ROUND_BIAS;
    assign shv  = full >>> 8;
    always_comb begin
        if ((&shv[FULL_W-1:OUT_W-1]) || !(|shv[FULL_W-1:OUT_W-1])) begin
            sat = shv[OUT_W-1:0];
        end else if (shv[FULL_W-1]) begin
            sat = OUT_MIN;
        end else begin
            sat = OUT_MAX;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.in_load) begin
            r_row   <= i_cell_row;
            r_col   <= i_cell_column;
            r_power <= i_heat_power;
        end
        if (i_cmd.cap_c) begin
            r_c <= r_rd;
        end
        if (i_cmd.cap_n) begin
            r_n <= r_rd;
        end
        if (i_cmd.cap_s) begin
            r_s <= r_rd;
        end
        if (i_cmd.cap_w) begin
            r_w <= r_rd;
        end
        if (i_cmd.acc_init) begin
            r_acc <= mul_p + src_term;
        end else if (i_cmd.acc_add) begin
            r_acc <= r_acc + mul_p;
        end
        if (i_cmd.pl_load) begin
            r_pl <= mul_p;
        end
        if (i_cmd.ph_load) begin
            r_ph <= mul_p;
        end
        if (i_cmd.out_load) begin
            r_out_data <= sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_derivative = r_out_data;

endmodule

// ===== src/heat_grid_stencil_derivative_top.sv =====
// Top level of the five-point heat stencil derivative block.
// Instantiates hgsd_ctrl and hgsd_datapath; uses hgsd_pkg.
//
// A write transaction stores one temperature. A compute transaction occupies
// the block until its result is loaded, and the next transaction is taken in
// the cycle after the load. The block steps through five reads of the
// single-port grid memory (center and four neighbors), four passes through
// one shared 27x17 multiplier, and a round and saturate step. The result sits
// in an output register, so a new transaction is taken while it waits; a
// second result waits in the final state until the output register is free.
// After reset a clearing pass over all MAX_ROWS*MAX_COLUMNS cells (4096 by
// default) sets every cell to 20.0; no transaction is accepted meanwhile,
// configuration writes are.
module heat_grid_stencil_derivative_top #(
    parameter int MAX_COLUMNS = hgsd_pkg::DEF_MAX_COLUMNS,
    parameter int MAX_ROWS    = hgsd_pkg::DEF_MAX_ROWS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [hgsd_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [hgsd_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic                               i_command,
    input  logic [hgsd_pkg::RC_W-1:0]          i_cell_row,
    input  logic [hgsd_pkg::RC_W-1:0]          i_cell_column,
    input  logic signed [hgsd_pkg::TEMP_W-1:0] i_temperature,
    input  logic signed [hgsd_pkg::TEMP_W-1:0] i_heat_power,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic signed [hgsd_pkg::OUT_W-1:0]  o_derivative
);
    import hgsd_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;

    hgsd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_command  (i_command),
        .i_status   (status),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    hgsd_datapath #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_cell_row    (i_cell_row),
        .i_cell_column (i_cell_column),
        .i_temperature (i_temperature),
        .i_heat_power  (i_heat_power),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_derivative  (o_derivative)
    );

endmodule

// ===== dv/tb_heat_grid_stencil_derivative_top.sv =====
// Testbench for heat_grid_stencil_derivative_top: cell writes and derivative computes
// with random handshake gaps, checked against an in-bench grid copy and stencil predictor.
// Depends on hgsd_pkg (src/hgsd_pkg.sv) and the RTL under src.
module tb_heat_grid_stencil_derivative_top;
    import hgsd_pkg::*;

    localparam int GRID_COLS   = DEF_MAX_COLUMNS;
    localparam int GRID_ROWS   = DEF_MAX_ROWS;
    localparam int IDLE_PCT    = 27;
    localparam int DRAIN_WAIT  = 16;
    localparam int FINAL_WAIT  = 5000;
    localparam int CYCLE_LIMIT = 500000;
    localparam int MAX_PRINTED = 50;
    localparam longint DERIV_MAX = (longint'(1) <<< (OUT_W - 1)) - 1;
    localparam longint DERIV_MIN = -DERIV_MAX - 1;
    localparam logic signed [TEMP_W-1:0] TEMP_MAX = {1'b0, {(TEMP_W-1){1'b1}}};
    localparam logic signed [TEMP_W-1:0] TEMP_MIN = {1'b1, {(TEMP_W-1){1'b0}}};

    logic                     i_clk = 1'b0;
    logic                     i_rst_n;
    logic                     i_cfg_we;
    logic [CFG_IDX_W-1:0]     i_cfg_index;
    logic [CFG_DATA_W-1:0]    i_cfg_data;
    logic                     i_in_valid;
    logic                     o_in_ready;
    logic                     i_command;
    logic [RC_W-1:0]          i_cell_row;
    logic [RC_W-1:0]          i_cell_column;
    logic signed [TEMP_W-1:0] i_temperature;
    logic signed [TEMP_W-1:0] i_heat_power;
    logic                     o_out_valid;
    logic                     i_out_ready = 1'b0;
    logic signed [OUT_W-1:0]  o_derivative;

    // predictor state
    logic signed [TEMP_W-1:0] cell_temps [GRID_ROWS*GRID_COLS];
    logic [GRID_W-1:0]        cfg_columns   = RST_GRID_COLUMNS;
    logic [GRID_W-1:0]        cfg_rows      = RST_GRID_ROWS;
    logic [COEF_W-1:0]        cfg_cond_x    = RST_COEF;
    logic [COEF_W-1:0]        cfg_cond_y    = RST_COEF;
    logic [COEF_W-1:0]        cfg_heat_gain = RST_COEF;
    logic [SRC_W-1:0]         cfg_source    = RST_SOURCE_CELL;

    logic signed [OUT_W-1:0]  expected_derivatives [$];
    int                       mismatch_count = 0;
    int                       cycle_count = 0;
    int                       in_idle_pct = IDLE_PCT;
    int                       out_idle_pct = IDLE_PCT;
    int                       out_hold = 0;

    heat_grid_stencil_derivative_top u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_command     (i_command),
        .i_cell_row    (i_cell_row),
        .i_cell_column (i_cell_column),
        .i_temperature (i_temperature),
        .i_heat_power  (i_heat_power),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_derivative  (o_derivative)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string what);
        if (mismatch_count < MAX_PRINTED)
            $display("MISMATCH cycle %0d: %s", cycle_count, what);
        mismatch_count++;
    endtask

    function automatic int used_dim(input int value, input int max_dim);
        if (value < 3)
            return 3;
        if (value > max_dim)
            return max_dim;
        return value;
    endfunction

    // five-point stencil with zero-flux edges, Q.24 product rounded to Q.16
    function automatic logic signed [OUT_W-1:0] predict_derivative(input int row, input int col,
            input logic signed [TEMP_W-1:0] power);
        int     cols_used;
        int     rows_used;
        longint center;
        longint north;
        longint south;
        longint west;
        longint east;
        longint flux;
        longint scaled;
        cols_used = used_dim(int'(cfg_columns), GRID_COLS);
        rows_used = used_dim(int'(cfg_rows), GRID_ROWS);
        flux = 0;
        if (row < rows_used && col < cols_used) begin
            if (row >= 1 && row + 2 <= rows_used && col >= 1 && col + 2 <= cols_used) begin
                center = cell_temps[row*GRID_COLS + col];
                north  = (row == 1) ? center : cell_temps[(row-1)*GRID_COLS + col];
                south  = (row + 2 == rows_used) ? center : cell_temps[(row+1)*GRID_COLS + col];
                west   = (col == 1) ? center : cell_temps[row*GRID_COLS + col - 1];
                east   = (col + 2 == cols_used) ? center : cell_temps[row*GRID_COLS + col + 1];
                flux = longint'(cfg_cond_y) * (north + south - 2*center)
                     + longint'(cfg_cond_x) * (west + east - 2*center);
            end
            if (row*cols_used + col == int'(cfg_source))
                flux += longint'(power) * 256;
        end
        scaled = (flux * longint'(cfg_heat_gain) + 128) >>> 8;
        if (scaled > DERIV_MAX)
            scaled = DERIV_MAX;
        if (scaled < DERIV_MIN)
            scaled = DERIV_MIN;
        return scaled[OUT_W-1:0];
    endfunction

    task automatic send_item(input logic command, input int row, input int col,
            input logic signed [TEMP_W-1:0] temperature, input logic signed [TEMP_W-1:0] power);
        while ($urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_command     <= command;
        i_cell_row    <= row[RC_W-1:0];
        i_cell_column <= col[RC_W-1:0];
        i_temperature <= temperature;
        i_heat_power  <= power;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        if (command == CMD_WRITE)
            cell_temps[row*GRID_COLS + col] = temperature;
        else
            expected_derivatives.push_back(predict_derivative(row, col, power));
    endtask

    task automatic write_cell(input int row, input int col,
            input logic signed [TEMP_W-1:0] temperature);
        logic signed [TEMP_W-1:0] junk;
        junk = TEMP_W'($urandom);
        send_item(CMD_WRITE, row, col, temperature, junk);
    endtask

    task automatic compute_cell(input int row, input int col,
            input logic signed [TEMP_W-1:0] power);
        logic signed [TEMP_W-1:0] junk;
        junk = TEMP_W'($urandom);
        send_item(CMD_COMPUTE, row, col, junk, power);
    endtask

    // let the block go idle; writes give no result, so allow them time to land
    task automatic drain();
        i_in_valid <= 1'b0;
        while (expected_derivatives.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input int value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value[CFG_DATA_W-1:0];
        @(posedge i_clk);
    endtask

    task automatic set_config(input int columns, input int rows, input int cond_x,
            input int cond_y, input int gain, input int source);
        write_reg(REG_GRID_COLUMNS, columns);
        write_reg(REG_GRID_ROWS, rows);
        write_reg(REG_CONDUCTANCE_X, cond_x);
        write_reg(REG_CONDUCTANCE_Y, cond_y);
        write_reg(REG_HEAT_GAIN, gain);
        write_reg(REG_SOURCE_CELL, source);
        i_cfg_we      <= 1'b0;
        cfg_columns   = columns[GRID_W-1:0];
        cfg_rows      = rows[GRID_W-1:0];
        cfg_cond_x    = cond_x[COEF_W-1:0];
        cfg_cond_y    = cond_y[COEF_W-1:0];
        cfg_heat_gain = gain[COEF_W-1:0];
        cfg_source    = source[SRC_W-1:0];
    endtask

    function automatic logic signed [TEMP_W-1:0] pick_temp();
        int                       spread;
        logic signed [TEMP_W-1:0] v;
        spread = int'($urandom_range(8191)) - 4096;
        case ($urandom_range(7))
            0, 1, 2, 3: v = TEMP_W'(RESET_TEMP + spread);
            4, 5:       v = TEMP_W'($urandom);
            6:          v = ($urandom_range(1) != 0) ? TEMP_MAX : TEMP_MIN;
            default:    v = TEMP_W'(spread);
        endcase
        return v;
    endfunction

    // lean toward both edges so edge-neighbor handling gets exercised
    function automatic int pick_index(input int used);
        case ($urandom_range(3))
            0:       return $urandom_range(2);
            1:       return used - 1 - int'($urandom_range(2));
            default: return $urandom_range(used - 1);
        endcase
    endfunction

    task automatic send_random_item();
        int rows_used;
        int cols_used;
        int row;
        int col;
        int pick;
        rows_used = used_dim(int'(cfg_rows), GRID_ROWS);
        cols_used = used_dim(int'(cfg_columns), GRID_COLS);
        row = pick_index(rows_used);
        col = pick_index(cols_used);
        pick = $urandom_range(99);
        if (pick < 10) begin
            row = $urandom_range(GRID_ROWS - 1);
            col = $urandom_range(GRID_COLS - 1);
        end else if (pick < 25 && int'(cfg_source) < rows_used*cols_used) begin
            row = int'(cfg_source) / cols_used;
            col = int'(cfg_source) % cols_used;
        end
        if ($urandom_range(99) < 40)
            send_item(CMD_WRITE, row, col, pick_temp(), pick_temp());
        else
            send_item(CMD_COMPUTE, row, col, pick_temp(), pick_temp());
    endtask

    task automatic test_reset_state();
        compute_cell(8, 8, 24'sd1000);
        compute_cell(0, 0, TEMP_MAX);
        compute_cell(15, 15, TEMP_MIN);
        write_cell(7, 8, TEMP_MAX);
        compute_cell(8, 8, TEMP_MIN);
        compute_cell(16, 3, TEMP_MAX);
        drain();
    endtask

    // 5 columns x 4 rows, source at (1,1)
    task automatic test_boundaries();
        set_config(5, 4, 384, 128, 512, 6);
        write_cell(0, 2, TEMP_MIN);
        write_cell(1, 2, -24'sd2560);
        write_cell(2, 2, 24'sd40000);
        write_cell(3, 2, TEMP_MAX);
        write_cell(1, 1, 24'sd7000);
        write_cell(1, 3, -24'sd300);
        compute_cell(1, 2, TEMP_MAX);
        compute_cell(2, 2, TEMP_MIN);
        compute_cell(1, 1, TEMP_MAX);
        compute_cell(0, 2, TEMP_MAX);
        compute_cell(3, 4, TEMP_MIN);
        compute_cell(4, 1, TEMP_MAX);
        compute_cell(1, 5, TEMP_MAX);
        write_cell(40, 63, TEMP_MIN);
        drain();
    endtask

    task automatic test_saturation();
        set_config(5, 5, 65535, 65535, 65535, 12);
        write_cell(2, 2, TEMP_MIN);
        write_cell(1, 2, TEMP_MAX);
        write_cell(3, 2, TEMP_MAX);
        write_cell(2, 1, TEMP_MAX);
        write_cell(2, 3, TEMP_MAX);
        compute_cell(2, 2, TEMP_MAX);
        write_cell(2, 2, TEMP_MAX);
        write_cell(1, 2, TEMP_MIN);
        write_cell(3, 2, TEMP_MIN);
        write_cell(2, 1, TEMP_MIN);
        write_cell(2, 3, TEMP_MIN);
        compute_cell(2, 2, TEMP_MIN);
        drain();
    endtask

    // grid sizes below and above the legal range, zero coefficients
    task automatic test_clamped_grid();
        set_config(0, 127, 256, 512, 256, 2);
        compute_cell(1, 1, TEMP_MAX);
        compute_cell(62, 1, TEMP_MAX);
        compute_cell(63, 1, TEMP_MAX);
        compute_cell(0, 2, TEMP_MAX);
        compute_cell(5, 3, TEMP_MAX);
        drain();
        set_config(127, 2, 0, 0, 0, 4095);
        compute_cell(1, 1, TEMP_MIN);
        compute_cell(1, 62, TEMP_MAX);
        compute_cell(2, 63, TEMP_MAX);
        drain();
    endtask

    task automatic test_back_to_back();
        in_idle_pct  = 0;
        out_idle_pct = 0;
        set_config(8, 8, $urandom_range(65535), $urandom_range(65535), $urandom_range(2048),
                   27);
        repeat (80) send_random_item();
        drain();
        in_idle_pct  = IDLE_PCT;
        out_idle_pct = IDLE_PCT;
    endtask

    task automatic test_output_stall();
        set_config(6, 6, 300, 700, 900, 14);
        out_hold = 200;
        repeat (40) send_random_item();
        drain();
    endtask

    task automatic test_random_settings();
        int columns;
        int rows;
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: begin columns = 3;  rows = 3;  end
                1: begin columns = 64; rows = 64; end
                2: begin columns = $urandom_range(3, 12); rows = $urandom_range(3, 12); end
                3: begin columns = $urandom_range(127); rows = $urandom_range(127); end
                4: begin columns = 4;  rows = 64; end
                default: begin columns = 64; rows = 4; end
            endcase
            if (phase == 1)
                set_config(columns, rows, 65535, 65535, 65535, $urandom_range(4095));
            else if (phase == 3)
                set_config(columns, rows, $urandom_range(65535), $urandom_range(65535),
                           $urandom_range(65535), $urandom_range(4095));
            else
                set_config(columns, rows, $urandom_range(4096), $urandom_range(4096),
                           $urandom_range(65535),
                           $urandom_range(used_dim(rows, GRID_ROWS)
                                          * used_dim(columns, GRID_COLS) - 1));
            repeat (75) send_random_item();
            drain();
        end
    endtask

    always @(posedge i_clk) begin : check_results
        logic signed [OUT_W-1:0] want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_derivatives.size() == 0) begin
                report_mismatch($sformatf("unexpected derivative %0d", o_derivative));
            end else begin
                want = expected_derivatives.pop_front();
                if (o_derivative !== want)
                    report_mismatch($sformatf("derivative %0d, expected %0d",
                                              o_derivative, want));
            end
        end
        if (out_hold > 0) begin
            out_hold--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= out_idle_pct);
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("tb_heat_grid_stencil_derivative_top: done, errors");
        $finish;
    end

    initial begin
        int waited;
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_index   <= REG_GRID_COLUMNS;
        i_cfg_data    <= '0;
        i_in_valid    <= 1'b0;
        i_command     <= CMD_WRITE;
        i_cell_row    <= '0;
        i_cell_column <= '0;
        i_temperature <= '0;
        i_heat_power  <= '0;
        for (int i = 0; i < GRID_ROWS*GRID_COLS; i++)
            cell_temps[i] = TEMP_W'(RESET_TEMP);
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_state();
        test_boundaries();
        test_saturation();
        test_clamped_grid();
        test_back_to_back();
        test_output_stall();
        test_random_settings();

        i_in_valid <= 1'b0;
        waited = 0;
        while (expected_derivatives.size() != 0 && waited < FINAL_WAIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (expected_derivatives.size() != 0)
            report_mismatch($sformatf("%0d derivatives never arrived",
                                      expected_derivatives.size()));
        if (mismatch_count == 0)
            $display("tb_heat_grid_stencil_derivative_top: done, clean");
        else
            $display("tb_heat_grid_stencil_derivative_top: done, errors");
        $finish;
    end

endmodule

// ===== files.f =====
src/hgsd_pkg.sv
src/hgsd_ctrl.sv
src/hgsd_datapath.sv
src/heat_grid_stencil_derivative_top.sv
dv/tb_heat_grid_stencil_derivative_top.sv
